@@ src/ddf_pkg.sv @@
`default_nettype none

package ddf_pkg;

    localparam int VALUE_W            = 32;
    localparam int COUNT_W            = 4;
    localparam int CHAR_W             = 8;
    localparam int DIGIT_W            = 4;
    localparam int RADIX              = 10;
    localparam int MAX_DIGITS_DEFAULT = 8;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    // control shared by every digit cell of the row
    typedef struct packed {
        logic clear;
        logic bit_shift;
        logic digit_shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/decimal_digit_formatter_core.sv @@
`default_nettype none
// conversion: after the item is taken, 32 conversion steps through the row of bcd cells and
// the alignment steps, then the characters out of the top cell, one per cycle while char_ready holds
// the bit-serial shift-add-3 conversion and the digit-wise shift out of the top cell keep the
// block busy, so it takes no new item until the last character of the item is loaded;
// an item with no digits is taken with no output and the block stays ready
// reset: rst_n asynchronous active low clears control and output valid; digits undefined

module decimal_digit_formatter_core
#(
    parameter int MAX_DIGITS = ddf_pkg::MAX_DIGITS_DEFAULT
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           item_valid,
    output logic                          item_ready,
    input  wire  [ddf_pkg::VALUE_W-1:0]   value,
    input  wire  [ddf_pkg::COUNT_W-1:0]   digit_count,
    input  wire                           blank_leading,
    output logic                          char_valid,
    input  wire                           char_ready,
    output logic [ddf_pkg::CHAR_W-1:0]    character,
    output logic                          last
);

    localparam int POS_W  = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W = $clog2(ddf_pkg::VALUE_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_ALIGN,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    logic [STEP_W-1:0]             step_reg;
    logic [POS_W-1:0]              left_reg;
    logic [POS_W-1:0]              count_reg;
    logic                          blank_reg;
    logic                          char_valid_reg;
    logic [ddf_pkg::VALUE_W-1:0]   value_reg;
    logic [ddf_pkg::CHAR_W-1:0]    char_reg;
    logic                          last_reg;

    logic                          accept;
    logic                          load;
    logic [POS_W-1:0]              count_sat;
    logic                          final_pos;
    logic                          is_space;
    logic [ddf_pkg::CHAR_W-1:0]    char_next;
    ddf_pkg::cell_ctrl_t           ctrl;

    logic [ddf_pkg::DIGIT_W-1:0]   digits [MAX_DIGITS];
    logic                          carries [MAX_DIGITS];

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign load       = (state_reg == S_EMIT) && (!char_valid_reg || char_ready);

    always_comb
    begin
        if (digit_count > ddf_pkg::COUNT_W'(MAX_DIGITS))
        begin
            count_sat = POS_W'(MAX_DIGITS);
        end
        else
        begin
            count_sat = POS_W'(digit_count);
        end
    end

    always_comb
    begin
        ctrl.clear       = accept;
        ctrl.bit_shift   = (state_reg == S_CONV);
        ctrl.digit_shift = (state_reg == S_ALIGN) || load;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_DIGITS; gi++)
        begin : g_cell
            logic                        bit_in;
            logic [ddf_pkg::DIGIT_W-1:0] digit_in;
            if (gi == 0)
            begin : g_low
                assign bit_in   = value_reg[ddf_pkg::VALUE_W-1];
                assign digit_in = '0;
            end
            else
            begin : g_up
                assign bit_in   = carries[gi-1];
                assign digit_in = digits[gi-1];
            end
            ddf_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .bit_in    (bit_in),
                .digit_in  (digit_in),
                .carry_out (carries[gi]),
                .digit     (digits[gi])
            );
        end
    endgenerate

    // top cell carries the next character
    assign final_pos = (left_reg == POS_W'(1));
    assign is_space  = !final_pos && blank_reg && (digits[MAX_DIGITS-1] == '0);

    always_comb
    begin
        if (is_space)
        begin
            char_next = ddf_pkg::ASCII_SPACE;
        end
        else
        begin
            char_next = ddf_pkg::ASCII_ZERO
                      + {{(ddf_pkg::CHAR_W-ddf_pkg::DIGIT_W){1'b0}}, digits[MAX_DIGITS-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            left_reg       <= '0;
            count_reg      <= '0;
            blank_reg      <= 1'b0;
            char_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_valid_reg && char_ready && !load)
            begin
                char_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && (count_sat != '0))
                    begin
                        state_reg <= S_CONV;
                        step_reg  <= '0;
                        count_reg <= count_sat;
                        blank_reg <= blank_leading;
                    end
                end
                S_CONV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(ddf_pkg::VALUE_W - 1))
                    begin
                        if (count_reg == POS_W'(MAX_DIGITS))
                        begin
                            state_reg <= S_EMIT;
                            left_reg  <= count_reg;
                        end
                        else
                        begin
                            state_reg <= S_ALIGN;
                            left_reg  <= POS_W'(MAX_DIGITS) - count_reg;
                        end
                    end
                end
                S_ALIGN:
                begin
                    if (left_reg == POS_W'(1))
                    begin
                        state_reg <= S_EMIT;
                        left_reg  <= count_reg;
                    end
                    else
                    begin
                        left_reg <= left_reg - POS_W'(1);
                    end
                end
                S_EMIT:
                begin
                    if (load)
                    begin
                        char_valid_reg <= 1'b1;
                        left_reg       <= left_reg - POS_W'(1);
                        if (!is_space && !final_pos)
                        begin
                            blank_reg <= 1'b0;
                        end
                        if (final_pos)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= value;
        end
        else if (state_reg == S_CONV)
        begin
            value_reg <= {value_reg[ddf_pkg::VALUE_W-2:0], 1'b0};
        end
        if (load)
        begin
            char_reg <= char_next;
            last_reg <= final_pos;
        end
    end

    assign char_valid = char_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

@@ src/ddf_cell.sv @@
`default_nettype none

module ddf_cell
(
    input  wire                              clk,
    input  wire ddf_pkg::cell_ctrl_t         ctrl,
    input  wire                              bit_in,
    input  wire  [ddf_pkg::DIGIT_W-1:0]      digit_in,
    output logic                             carry_out,
    output logic [ddf_pkg::DIGIT_W-1:0]      digit
);

    localparam int HALF   = ddf_pkg::RADIX / 2;
    localparam int ADJUST = ((1 << ddf_pkg::DIGIT_W) - ddf_pkg::RADIX) / 2;

    logic [ddf_pkg::DIGIT_W-1:0] digit_reg;
    logic [ddf_pkg::DIGIT_W-1:0] digit_next;
    logic [ddf_pkg::DIGIT_W-1:0] adjusted;

    // add-3 correction before the doubling step
    always_comb
    begin
        if (digit_reg >= ddf_pkg::DIGIT_W'(HALF))
        begin
            adjusted = digit_reg + ddf_pkg::DIGIT_W'(ADJUST);
        end
        else
        begin
            adjusted = digit_reg;
        end
    end

    always_comb
    begin
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.bit_shift)
        begin
            digit_next = {adjusted[ddf_pkg::DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.digit_shift)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign carry_out = adjusted[ddf_pkg::DIGIT_W-1];
    assign digit     = digit_reg;

endmodule

`default_nettype wire

@@ src/ddf_checker.sv @@
`default_nettype none

module ddf_checker
(
    input wire                         clk,
    input wire                         rst_n,
    input wire                         item_valid,
    input wire                         item_ready,
    input wire [ddf_pkg::COUNT_W-1:0]  digit_count,
    input wire                         char_valid,
    input wire                         char_ready,
    input wire [ddf_pkg::CHAR_W-1:0]   character,
    input wire                         last
);

    // a number with digits keeps the block busy while it converts
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (digit_count != '0) |=> !item_ready)
    else $error("input ready straight after an item with digits");

    a_char_hold: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && !char_ready |=> char_valid && $stable(character) && $stable(last))
    else $error("stalled character changed");

    a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> (character == ddf_pkg::ASCII_SPACE)
                    || ((character >= ddf_pkg::ASCII_ZERO)
                        && (character <= ddf_pkg::ASCII_ZERO + 8'd9)))
    else $error("character is neither digit nor space");

    // the final position is always a digit
    a_last_digit: assert property (@(posedge clk) disable iff (!rst_n)
        char_valid && last |-> (character != ddf_pkg::ASCII_SPACE))
    else $error("last character blanked");

endmodule

bind decimal_digit_formatter_core ddf_checker u_ddf_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .digit_count   (digit_count),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .character     (character),
    .last          (last)
);

`default_nettype wire
